[hw/rtl/ctp_pkg.sv]
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants of the chart trace plotter.
// ----------------------------------------------------------------------------
package ctp_pkg;

    // divider geometry: dividend covers the larger of both numerators
    localparam int DIV_DW  = 46;          // dividend / quotient bits
    localparam int DIV_VW  = 33;          // divisor / remainder bits
    localparam int DIV_CYC = DIV_DW / 2;  // two quotient bits per cycle
    localparam int DIV_CW  = $clog2(DIV_CYC);

    // draw_mode bit positions
    localparam int DM_EXT_LEFT  = 0;
    localparam int DM_SKIP_GAPS = 1;
    localparam int DM_EXT_RIGHT = 2;
    localparam int DM_DOT_ICON  = 3;

    // command kinds
    localparam logic CMD_LINE  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        REG_AREA_LEFT    = 3'd0,
        REG_AREA_BOTTOM  = 3'd1,
        REG_AREA_WIDTH   = 3'd2,
        REG_AREA_HEIGHT  = 3'd3,
        REG_COLUMN_COUNT = 3'd4,
        REG_Y_MIN        = 3'd5,
        REG_Y_MAX        = 3'd6,
        REG_DRAW_MODE    = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_NEVER = 2'd0,
        PH_DRAW  = 2'd1,
        PH_GAP   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIVX,
        S_LOADY,
        S_DIVY,
        S_PLAN,
        S_EMIT
    } t_state;

    // command slots in emission order
    localparam logic [2:0] SLOT_MAIN  = 3'd0;
    localparam logic [2:0] SLOT_LEFT  = 3'd1;
    localparam logic [2:0] SLOT_RIGHT = 3'd2;
    localparam logic [2:0] SLOT_UP    = 3'd3;
    localparam logic [2:0] SLOT_DOWN  = 3'd4;
    localparam logic [2:0] SLOT_EXTR  = 3'd5;

    typedef struct packed {
        logic               sample_present;
        logic signed [31:0] sample_value;
        logic               last_column;
    } t_in_item;

    typedef struct packed {
        logic               command_kind;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               last_of_run;
    } t_out_item;

endpackage

[hw/rtl/chart_trace_plotter_top.sv]
// ----------------------------------------------------------------------------
// chart_trace_plotter_top
// Flow: a present column passes S_PREP, the x division, S_LOADY, the y division
// and S_PLAN before its main command is emitted; a missing column goes straight
// to S_PLAN. Emission, if any, then scans six command slots at one per cycle
// (output not stalled). A present column's run time is set mostly by the shared
// radix-4 divider, run twice. One item at a time. Synchronous active-low reset
// clears trace state, config and output valid.
// ----------------------------------------------------------------------------
module chart_trace_plotter_top
    import ctp_pkg::*;
#(
    parameter int COORD_BITS  = 16,
    parameter int COLUMN_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_in_data,
    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_out_data,
    // configuration (APB style)
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam int XPW = 14 + COLUMN_BITS;  // x numerator bits

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic        [11:0] r_area_left;
    logic        [12:0] r_area_bottom;
    logic        [12:0] r_area_width;
    logic        [12:0] r_area_height;
    logic        [15:0] r_column_count;
    logic signed [31:0] r_y_min;
    logic signed [31:0] r_y_max;
    logic        [3:0]  r_draw_mode;

    t_reg_idx w_reg_idx;
    logic     w_cfg_wr;

    assign w_reg_idx = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_left    <= 12'd0;
            r_area_bottom  <= 13'd240;
            r_area_width   <= 13'd320;
            r_area_height  <= 13'd240;
            r_column_count <= 16'd1;
            r_y_min        <= 32'sd0;
            r_y_max        <= 32'sd1;
            r_draw_mode    <= 4'd8;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_AREA_LEFT:    r_area_left    <= pwdata[11:0];
                REG_AREA_BOTTOM:  r_area_bottom  <= pwdata[12:0];
                REG_AREA_WIDTH:   r_area_width   <= pwdata[12:0];
                REG_AREA_HEIGHT:  r_area_height  <= pwdata[12:0];
                REG_COLUMN_COUNT: r_column_count <= pwdata[15:0];
                REG_Y_MIN:        r_y_min        <= pwdata;
                REG_Y_MAX:        r_y_max        <= pwdata;
                REG_DRAW_MODE:    r_draw_mode    <= pwdata[3:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_AREA_LEFT:    prdata = {20'd0, r_area_left};
            REG_AREA_BOTTOM:  prdata = {19'd0, r_area_bottom};
            REG_AREA_WIDTH:   prdata = {19'd0, r_area_width};
            REG_AREA_HEIGHT:  prdata = {19'd0, r_area_height};
            REG_COLUMN_COUNT: prdata = {16'd0, r_column_count};
            REG_Y_MIN:        prdata = r_y_min;
            REG_Y_MAX:        prdata = r_y_max;
            REG_DRAW_MODE:    prdata = {28'd0, r_draw_mode};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // trace state and captured item
    // ------------------------------------------------------------------
    t_state                   r_state, n_state;
    t_phase                   r_phase;
    t_coord                   r_prev_x, r_prev_y;
    logic [COLUMN_BITS-1:0]   r_col;

    logic                     r_present, r_last;
    logic signed [31:0]       r_value;

    // y numerator magnitude, sign and divisor, formed in S_PREP before x divides
    logic [DIV_VW-1:0]        r_ymag;
    logic                     r_yneg;
    logic [DIV_VW-1:0]        r_wh;

    // shared divider: dividend shifts out as quotient shifts in
    logic [DIV_DW-1:0]        r_num;
    logic [DIV_VW-1:0]        r_rem;
    logic [DIV_VW-1:0]        r_den;
    logic [DIV_CW-1:0]        r_cnt;

    t_coord                   r_px, r_py;

    // planned commands
    logic [5:0]               r_mask;
    logic [2:0]               r_slot;
    logic                     r_main_kind;
    t_coord                   r_m_sx, r_m_sy, r_m_ex, r_m_ey;
    t_coord                   r_er_x, r_er_y;

    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_accept;
    logic                     w_out_free;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

    // ------------------------------------------------------------------
    // divider step: two restoring compare/subtract stages
    // ------------------------------------------------------------------
    logic [DIV_VW:0]   w_t1, w_t2;
    logic              w_ge1, w_ge2;
    logic [DIV_VW-1:0] w_rem1, w_rem2;
    logic [DIV_DW-1:0] w_num1, w_num2;

    always_comb begin
        w_t1   = {r_rem, r_num[DIV_DW-1]};
        w_ge1  = (w_t1 >= {1'b0, r_den});
        w_rem1 = w_ge1 ? DIV_VW'(w_t1 - {1'b0, r_den}) : w_t1[DIV_VW-1:0];
        w_num1 = {r_num[DIV_DW-2:0], w_ge1};
        w_t2   = {w_rem1, w_num1[DIV_DW-1]};
        w_ge2  = (w_t2 >= {1'b0, r_den});
        w_rem2 = w_ge2 ? DIV_VW'(w_t2 - {1'b0, r_den}) : w_t2[DIV_VW-1:0];
        w_num2 = {w_num1[DIV_DW-2:0], w_ge2};
    end

    // ------------------------------------------------------------------
    // operand preparation
    // ------------------------------------------------------------------
    logic [XPW-1:0]     w_numx;      // width * (2i+1)
    logic [15:0]        w_cc;
    logic signed [32:0] w_ydiff;
    logic signed [33:0] w_wh;
    logic [DIV_DW-1:0]  w_numy;

    assign w_numx  = XPW'(r_area_width) * XPW'({r_col, 1'b1});
    assign w_cc    = (r_column_count == 16'd0) ? 16'd1 : r_column_count;
    assign w_ydiff = 33'(r_value) - 33'(r_y_min);
    assign w_wh    = 34'(r_y_max) - 34'(r_y_min) + 34'sd1;
    assign w_numy  = DIV_DW'(r_ymag) * DIV_DW'(r_area_height);

    // ------------------------------------------------------------------
    // screen coordinates (wrap to COORD_BITS)
    // ------------------------------------------------------------------
    t_coord w_left, w_right_m1, w_px, w_py, w_qy, w_base;

    assign w_left     = COORD_BITS'(r_area_left);
    assign w_right_m1 = w_left + COORD_BITS'(r_area_width) - t_coord'(1);
    assign w_px       = w_left + r_num[COORD_BITS-1:0];
    assign w_qy       = r_num[COORD_BITS-1:0];
    assign w_base     = COORD_BITS'(r_area_bottom) - t_coord'(1);
    assign w_py       = r_yneg ? (w_base + w_qy) : (w_base - w_qy);

    // ------------------------------------------------------------------
    // command planning (evaluated in S_PLAN; x was latched in S_LOADY)
    // ------------------------------------------------------------------
    logic   w_main_en, w_main_kind, w_er_en;
    t_coord w_m_sx, w_m_sy, w_m_ex, w_m_ey;
    t_phase w_new_phase;
    t_coord w_new_x, w_new_y;

    always_comb begin
        w_main_en   = 1'b0;
        w_main_kind = CMD_PIXEL;
        w_m_sx      = r_px;
        w_m_sy      = w_py;
        w_m_ex      = '0;
        w_m_ey      = '0;
        w_new_phase = r_phase;
        w_new_x     = r_prev_x;
        w_new_y     = r_prev_y;
        if (r_present) begin
            w_new_phase = PH_DRAW;
            w_new_x     = r_px;
            w_new_y     = w_py;
            if (r_phase == PH_DRAW) begin
                // join from the previous point
                w_main_en   = 1'b1;
                w_main_kind = CMD_LINE;
                w_m_sx      = r_prev_x;
                w_m_sy      = r_prev_y;
                w_m_ex      = r_px;
                w_m_ey      = w_py;
            end else if (r_phase == PH_NEVER && r_draw_mode[DM_EXT_LEFT]) begin
                // extend left: nothing if the point sits on or left of the edge
                w_main_en   = (r_px > w_left);
                w_main_kind = CMD_LINE;
                w_m_sx      = w_left + t_coord'(1);
                w_m_sy      = w_py;
                w_m_ex      = r_px;
                w_m_ey      = w_py;
            end else begin
                w_main_en   = 1'b1;
            end
        end else if (r_phase == PH_DRAW && r_draw_mode[DM_SKIP_GAPS]) begin
            w_new_phase = PH_GAP;
        end
        w_er_en = r_last && r_draw_mode[DM_EXT_RIGHT] && (w_new_phase != PH_NEVER)
                  && (w_new_x < w_right_m1);
    end

    // ------------------------------------------------------------------
    // command emission
    // ------------------------------------------------------------------
    function automatic logic [15:0] f_out(input t_coord v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    logic      w_slot_en, w_later, w_emit_go;
    t_out_item w_cmd;

    assign w_slot_en = r_mask[r_slot];
    assign w_later   = |(r_mask & (6'b111110 << r_slot));
    assign w_emit_go = (r_state == S_EMIT) && w_slot_en && w_out_free;

    always_comb begin
        w_cmd.command_kind = CMD_PIXEL;
        w_cmd.start_x      = f_out(r_px);
        w_cmd.start_y      = f_out(r_py);
        w_cmd.end_x        = 16'd0;
        w_cmd.end_y        = 16'd0;
        w_cmd.last_of_run  = !w_later;
        case (r_slot)
            SLOT_MAIN: begin
                w_cmd.command_kind = r_main_kind;
                w_cmd.start_x      = f_out(r_m_sx);
                w_cmd.start_y      = f_out(r_m_sy);
                w_cmd.end_x        = f_out(r_m_ex);
                w_cmd.end_y        = f_out(r_m_ey);
            end
            SLOT_LEFT:  w_cmd.start_x = f_out(r_px - t_coord'(1));
            SLOT_RIGHT: w_cmd.start_x = f_out(r_px + t_coord'(1));
            SLOT_UP:    w_cmd.start_y = f_out(r_py - t_coord'(1));
            SLOT_DOWN:  w_cmd.start_y = f_out(r_py + t_coord'(1));
            SLOT_EXTR: begin
                w_cmd.command_kind = CMD_LINE;
                w_cmd.start_x      = f_out(r_er_x);
                w_cmd.start_y      = f_out(r_er_y);
                w_cmd.end_x        = f_out(w_right_m1);
                w_cmd.end_y        = f_out(r_er_y);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_in_data.sample_present ? S_PREP : S_PLAN;
                end
            end
            S_PREP:  n_state = S_DIVX;
            S_DIVX:  if (r_cnt == '0) n_state = S_LOADY;
            S_LOADY: n_state = S_DIVY;
            S_DIVY:  if (r_cnt == '0) n_state = S_PLAN;
            S_PLAN: begin
                n_state = ({w_er_en, {4{r_present && r_draw_mode[DM_DOT_ICON]}},
                            w_main_en} == 6'd0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (r_slot == SLOT_EXTR && (!w_slot_en || w_out_free)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // trace state and output register (control)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NEVER;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_slot      <= SLOT_MAIN;
        end else begin
            if (r_state == S_PLAN) begin
                r_slot <= SLOT_MAIN;
                if (r_last) begin
                    r_phase  <= PH_NEVER;
                    r_prev_x <= '0;
                    r_prev_y <= '0;
                    r_col    <= '0;
                end else begin
                    r_phase  <= w_new_phase;
                    r_prev_x <= w_new_x;
                    r_prev_y <= w_new_y;
                    r_col    <= r_col + 1'b1;
                end
            end
            if (r_state == S_EMIT && (!w_slot_en || w_out_free)) begin
                r_slot <= r_slot + 3'd1;
            end
            if (w_emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_emit_go) begin
            r_out <= w_cmd;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_present <= i_in_data.sample_present;
                    r_value   <= i_in_data.sample_value;
                    r_last    <= i_in_data.last_column;
                end
            end
            S_PREP: begin
                r_num  <= DIV_DW'(w_numx);
                r_den  <= DIV_VW'({w_cc, 1'b0});
                r_rem  <= '0;
                r_cnt  <= DIV_CW'(DIV_CYC - 1);
                r_yneg <= w_ydiff[32];
                r_ymag <= w_ydiff[32] ? DIV_VW'(-w_ydiff) : DIV_VW'(w_ydiff);
                // a non-positive span divides by one
                r_wh   <= (w_wh[33] || w_wh == 34'sd0) ? DIV_VW'(1) : w_wh[DIV_VW-1:0];
            end
            S_DIVX, S_DIVY: begin
                r_num <= w_num2;
                r_rem <= w_rem2;
                r_cnt <= r_cnt - 1'b1;
            end
            S_LOADY: begin
                r_px  <= w_px;
                r_num <= w_numy;
                r_den <= r_wh;
                r_rem <= '0;
                r_cnt <= DIV_CW'(DIV_CYC - 1);
            end
            S_PLAN: begin
                r_py        <= w_py;
                r_mask      <= {w_er_en, {4{r_present && r_draw_mode[DM_DOT_ICON]}},
                                w_main_en};
                r_main_kind <= w_main_kind;
                r_m_sx      <= w_m_sx;
                r_m_sy      <= w_m_sy;
                r_m_ex      <= w_m_ex;
                r_m_ey      <= w_m_ey;
                r_er_x      <= w_new_x;
                r_er_y      <= w_new_y;
            end
            S_EMIT: ;
            default: ;
        endcase
    end

endmodule

[test/chart_trace_plotter_top_test.sv]
// ----------------------------------------------------------------------------
// chart_trace_plotter_top_test
// Self-checking bench for the chart trace plotter. A table of directed
// columns and register writes runs first, then random rows under random
// settings follow. Each accepted column is run through a local model of the
// trace logic. The commands it yields are queued and checked field by field
// against the commands the block hands out. Both channels idle in random
// bursts.
// ----------------------------------------------------------------------------
module chart_trace_plotter_top_test;
    import ctp_pkg::*;

    // slack after the last expected command before the block counts as idle:
    // a present column keeps the block busy through both divisions even when it
    // yields nothing
    localparam int SETTLE_CYCLES = 80;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_in_item    i_in_data  = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_out_item   o_out_data;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    always #1 i_clk = ~i_clk;

    chart_trace_plotter_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // Model state: a copy of the registers and of the trace state
    // ------------------------------------------------------------------
    longint      cfg_left, cfg_bottom, cfg_width, cfg_height, cfg_cols;
    longint      cfg_ymin, cfg_ymax;
    logic [3:0]  cfg_mode;
    t_phase      trace_ph;
    longint      prev_x, prev_y;
    logic [15:0] col_idx;

    // commands of the column just predicted, in emission order
    t_out_item   col_cmds [6];
    int          col_n;

    t_out_item   expected_cmds [$];
    int          fail_count = 0;
    bit          quiet      = 1'b0;   // no idling on either side when set
    int          stall_left = 0;

    // directed plan: either a register write or a column
    typedef struct {
        bit        is_cfg;
        t_reg_idx  reg_sel;
        logic [31:0] reg_val;
        t_in_item  item;
        bit        typed;             // first command given by hand
        t_out_item first;
    } t_step;

    t_step plan [$];

    // ------------------------------------------------------------------
    // Trace model
    // ------------------------------------------------------------------
    // screen coordinates wrap to 16 bits two's complement
    function automatic longint wrap_c(longint v);
        logic signed [15:0] s;
        s = v[15:0];
        return s;
    endfunction

    function automatic t_out_item draw_cmd(logic kind, longint sx, longint sy,
                                           longint ex, longint ey, logic last);
        t_out_item c;
        c.command_kind = kind;
        c.start_x      = sx[15:0];
        c.start_y      = sy[15:0];
        c.end_x        = ex[15:0];
        c.end_y        = ey[15:0];
        c.last_of_run  = last;
        return c;
    endfunction

    function automatic void add_cmd(logic kind, longint sx, longint sy,
                                    longint ex, longint ey);
        col_cmds[col_n] = draw_cmd(kind, sx, sy, ex, ey, 1'b0);
        col_n++;
    endfunction

    function automatic void model_reset();
        cfg_left   = 0;
        cfg_bottom = 240;
        cfg_width  = 320;
        cfg_height = 240;
        cfg_cols   = 1;
        cfg_ymin   = 0;
        cfg_ymax   = 1;
        cfg_mode   = 4'd8;
        trace_ph   = PH_NEVER;
        prev_x     = 0;
        prev_y     = 0;
        col_idx    = '0;
    endfunction

    // maps one column and runs the phase machine; fills col_cmds
    function automatic void trace_column(t_in_item it);
        longint edge_l, right_m1, cc, ci, numx, px, span, v, numy, py;
        col_n    = 0;
        edge_l   = wrap_c(cfg_left);
        right_m1 = wrap_c(cfg_left + cfg_width - 1);
        if (it.sample_present) begin
            cc   = (cfg_cols == 0) ? 1 : cfg_cols;   // zero count divides by one
            ci   = col_idx;
            numx = cfg_width * (2 * ci + 1);
            px   = wrap_c(cfg_left + numx / (2 * cc));
            span = cfg_ymax - cfg_ymin + 1;
            if (span <= 0)
                span = 1;                            // inverted range
            v    = $signed(it.sample_value);
            numy = cfg_height * (v - cfg_ymin);
            py   = wrap_c(cfg_bottom - 1 - numy / span);

            if (trace_ph == PH_DRAW) begin
                add_cmd(CMD_LINE, prev_x, prev_y, px, py);
            end else if (trace_ph == PH_NEVER && cfg_mode[DM_EXT_LEFT]) begin
                if (px > edge_l)
                    add_cmd(CMD_LINE, wrap_c(edge_l + 1), py, px, py);
            end else begin
                add_cmd(CMD_PIXEL, px, py, 0, 0);
            end
            if (cfg_mode[DM_DOT_ICON]) begin
                add_cmd(CMD_PIXEL, wrap_c(px - 1), py, 0, 0);
                add_cmd(CMD_PIXEL, wrap_c(px + 1), py, 0, 0);
                add_cmd(CMD_PIXEL, px, wrap_c(py - 1), 0, 0);
                add_cmd(CMD_PIXEL, px, wrap_c(py + 1), 0, 0);
            end
            prev_x   = px;
            prev_y   = py;
            trace_ph = PH_DRAW;
        end else if (trace_ph == PH_DRAW && cfg_mode[DM_SKIP_GAPS]) begin
            trace_ph = PH_GAP;
        end

        if (it.last_column) begin
            if (cfg_mode[DM_EXT_RIGHT] && trace_ph != PH_NEVER && prev_x < right_m1)
                add_cmd(CMD_LINE, prev_x, prev_y, right_m1, prev_y);
            trace_ph = PH_NEVER;
            prev_x   = 0;
            prev_y   = 0;
            col_idx  = '0;
        end else begin
            col_idx = col_idx + 16'd1;
        end

        if (col_n > 0)
            col_cmds[col_n - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: everything changes on the falling edge
    // ------------------------------------------------------------------
    task automatic set_reg(input t_reg_idx sel, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {sel, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (sel)
            REG_AREA_LEFT:    cfg_left   = val[11:0];
            REG_AREA_BOTTOM:  cfg_bottom = val[12:0];
            REG_AREA_WIDTH:   cfg_width  = val[12:0];
            REG_AREA_HEIGHT:  cfg_height = val[12:0];
            REG_COLUMN_COUNT: cfg_cols   = val[15:0];
            REG_Y_MIN:        cfg_ymin   = $signed(val);
            REG_Y_MAX:        cfg_ymax   = $signed(val);
            REG_DRAW_MODE:    cfg_mode   = val[3:0];
            default: ;
        endcase
    endtask

    // hands one column over and queues what it should yield
    task automatic send_column(input t_in_item it, input int gap,
                               input bit typed, input t_out_item first);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (o_stall);
        trace_column(it);
        if (typed && col_n > 0)
            col_cmds[0] = first;
        for (int k = 0; k < col_n; k++)
            expected_cmds.insert(expected_cmds.size(), col_cmds[k]);
    endtask

    // sender holds off until every queued command has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    // block idle: nothing queued and a column without output worked off
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 5) != 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return 32'd1;
            1:       return 32'd4096;
            2:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, 600);
        endcase
    endfunction

    // mostly inside (or just outside) the vertical range, else anything
    function automatic logic [31:0] random_value();
        longint span;
        span = cfg_ymax - cfg_ymin;
        if ($urandom_range(0, 3) != 0 && span >= 0 && span < 100000)
            return 32'(cfg_ymin - 8 + $urandom_range(0, span + 16));
        return $urandom;
    endfunction

    // flavour 0: all minimum, 1: all maximum, else random
    task automatic random_setting(input int flavour);
        logic [31:0] lo, hi;
        if (flavour == 0) begin
            set_reg(REG_AREA_LEFT, 32'd0);
            set_reg(REG_AREA_BOTTOM, 32'd1);
            set_reg(REG_AREA_WIDTH, 32'd1);
            set_reg(REG_AREA_HEIGHT, 32'd1);
            set_reg(REG_COLUMN_COUNT, 32'd1);
            set_reg(REG_Y_MIN, 32'h8000_0000);
            set_reg(REG_Y_MAX, 32'h8000_0000);
            set_reg(REG_DRAW_MODE, 32'd0);
        end else if (flavour == 1) begin
            set_reg(REG_AREA_LEFT, 32'd4095);
            set_reg(REG_AREA_BOTTOM, 32'd4096);
            set_reg(REG_AREA_WIDTH, 32'd4096);
            set_reg(REG_AREA_HEIGHT, 32'd4096);
            set_reg(REG_COLUMN_COUNT, 32'd65535);
            set_reg(REG_Y_MIN, 32'h8000_0000);
            set_reg(REG_Y_MAX, 32'h7FFF_FFFF);
            set_reg(REG_DRAW_MODE, 32'd15);
        end else begin
            set_reg(REG_AREA_LEFT,
                    ($urandom_range(0, 3) == 0) ? 32'd4095 : $urandom_range(0, 600));
            set_reg(REG_AREA_BOTTOM, pick_size());
            set_reg(REG_AREA_WIDTH, pick_size());
            set_reg(REG_AREA_HEIGHT, pick_size());
            case ($urandom_range(0, 9))
                0:       set_reg(REG_COLUMN_COUNT, 32'd0);
                1:       set_reg(REG_COLUMN_COUNT, 32'd65535);
                2:       set_reg(REG_COLUMN_COUNT, $urandom_range(0, 65535));
                default: set_reg(REG_COLUMN_COUNT, $urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 7))
                0: begin
                    lo = $urandom;          // may well be inverted
                    hi = $urandom;
                end
                1: begin
                    lo = 32'h8000_0000;
                    hi = 32'h7FFF_FFFF;
                end
                default: begin
                    lo = $urandom_range(0, 2000) - 1000;
                    hi = lo + $urandom_range(0, 3000);
                end
            endcase
            set_reg(REG_Y_MIN, lo);
            set_reg(REG_Y_MAX, hi);
            set_reg(REG_DRAW_MODE, $urandom_range(0, 15));
        end
    endtask

    // rows of columns; a few rows lack their last mark and run on
    task automatic random_rows(input int n_items, input int hold_at);
        t_in_item it;
        int       sent;
        int       len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30)
                                              : $urandom_range(1, 8);
            for (int k = 0; k < len && sent < n_items; k++) begin
                if (sent == hold_at)
                    drain_results();
                it.sample_present = ($urandom_range(0, 4) != 0);
                it.sample_value   = random_value();
                it.last_column    = (k == len - 1) && ($urandom_range(0, 9) != 0);
                send_column(it, pick_gap(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    function automatic void add_cfg(t_reg_idx sel, logic [31:0] val);
        t_step s;
        s.is_cfg  = 1'b1;
        s.reg_sel = sel;
        s.reg_val = val;
        s.item    = '0;
        s.typed   = 1'b0;
        s.first   = '0;
        plan.insert(plan.size(), s);
    endfunction

    function automatic void add_col(logic present, logic [31:0] val, logic last,
                                    bit typed, t_out_item first);
        t_step s;
        s.is_cfg              = 1'b0;
        s.reg_sel             = REG_AREA_LEFT;
        s.reg_val             = '0;
        s.item.sample_present = present;
        s.item.sample_value   = val;
        s.item.last_column    = last;
        s.typed               = typed;
        s.first               = first;
        plan.insert(plan.size(), s);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts, checking at the rising edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(1, 16);
        i_stall = (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    t_out_item want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cmds.size() == 0) begin
                $display("%0t: command with none expected, expected none, got %h",
                         $time, o_out_data);
                fail_count++;
            end else begin
                want = expected_cmds.pop_front();
                check_field("command_kind", want.command_kind, o_out_data.command_kind);
                check_field("start_x", want.start_x, o_out_data.start_x);
                check_field("start_y", want.start_y, o_out_data.start_y);
                check_field("end_x", want.end_x, o_out_data.end_x);
                check_field("end_y", want.end_y, o_out_data.end_y);
                check_field("last_of_run", want.last_of_run, o_out_data.last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------
    // Run-away guard, far beyond the slowest legal run
    // ------------------------------------------------------------------
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        model_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: dots on, single column at x 160
        add_col(1'b1, 32'd0, 1'b1, 1'b1, draw_cmd(CMD_PIXEL, 160, 239, 0, 0, 1'b0));
        add_col(1'b1, 32'd1, 1'b1, 1'b1, draw_cmd(CMD_PIXEL, 160, 119, 0, 0, 1'b0));
        add_col(1'b0, 32'd0, 1'b1, 1'b0, '0);
        // four columns at x 150/250/350/450, y = 199 - value
        add_cfg(REG_DRAW_MODE, 32'd0);
        add_cfg(REG_COLUMN_COUNT, 32'd4);
        add_cfg(REG_AREA_LEFT, 32'd100);
        add_cfg(REG_AREA_WIDTH, 32'd400);
        add_cfg(REG_AREA_HEIGHT, 32'd200);
        add_cfg(REG_AREA_BOTTOM, 32'd300);
        add_cfg(REG_Y_MIN, -32'sd100);
        add_cfg(REG_Y_MAX, 32'd99);
        add_col(1'b1, 32'd0, 1'b0, 1'b1, draw_cmd(CMD_PIXEL, 150, 199, 0, 0, 1'b1));
        add_col(1'b1, 32'd50, 1'b0, 1'b1, draw_cmd(CMD_LINE, 150, 199, 250, 149, 1'b1));
        // missing column without skip gaps: line carries on
        add_col(1'b0, 32'd7, 1'b0, 1'b0, '0);
        add_col(1'b1, -32'sd100, 1'b1, 1'b1, draw_cmd(CMD_LINE, 250, 149, 450, 299, 1'b1));
        // every mode bit: extend left, gap, pixel after gap, extend right
        add_cfg(REG_DRAW_MODE, 32'd15);
        add_col(1'b1, 32'd99, 1'b0, 1'b1, draw_cmd(CMD_LINE, 101, 100, 150, 100, 1'b0));
        add_col(1'b0, 32'd0, 1'b0, 1'b0, '0);
        add_col(1'b1, -32'sd50, 1'b0, 1'b1, draw_cmd(CMD_PIXEL, 350, 249, 0, 0, 1'b0));
        add_col(1'b0, 32'd0, 1'b1, 1'b1, draw_cmd(CMD_LINE, 350, 249, 499, 249, 1'b1));
        add_col(1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0, '0);
        add_col(1'b1, 32'h8000_0000, 1'b1, 1'b0, '0);
        // point lands on the left edge: extend left draws nothing
        add_cfg(REG_AREA_WIDTH, 32'd1);
        add_cfg(REG_COLUMN_COUNT, 32'd65535);
        add_col(1'b1, 32'd0, 1'b1, 1'b0, '0);
        // zero column count
        add_cfg(REG_AREA_WIDTH, 32'd4096);
        add_cfg(REG_COLUMN_COUNT, 32'd0);
        add_col(1'b1, 32'd5, 1'b0, 1'b0, '0);
        add_col(1'b1, 32'd6, 1'b1, 1'b0, '0);
        // inverted vertical range
        add_cfg(REG_Y_MIN, 32'd10);
        add_cfg(REG_Y_MAX, -32'sd10);
        add_col(1'b1, 32'd3, 1'b1, 1'b0, '0);
        // widest area, full world range, values far out
        add_cfg(REG_AREA_LEFT, 32'd4095);
        add_cfg(REG_AREA_WIDTH, 32'd8191);
        add_cfg(REG_AREA_BOTTOM, 32'd8191);
        add_cfg(REG_AREA_HEIGHT, 32'd8191);
        add_cfg(REG_COLUMN_COUNT, 32'd1);
        add_cfg(REG_Y_MIN, 32'h8000_0000);
        add_cfg(REG_Y_MAX, 32'h7FFF_FFFF);
        add_col(1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
        add_col(1'b1, 32'h8000_0000, 1'b1, 1'b0, '0);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                set_reg(plan[i].reg_sel, plan[i].reg_val);
            end else begin
                send_column(plan[i].item, pick_gap(), plan[i].typed, plan[i].first);
            end
        end

        // random rows; last phases run without idling
        for (int p = 0; p < 11; p++) begin
            settle();
            quiet = (p >= 9);
            random_setting(p);
            random_rows(18, (p == 4) ? 10 : -1);
        end

        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
